// ----- rtl/core/sap_pkg.sv -----
package sap_pkg;

   localparam int unsigned HDR_BYTES      = 20;
   localparam int unsigned ATTR_HDR_BYTES = 4;
   localparam int unsigned ADDR_VALUE_LEN = 8;
   localparam int unsigned CAPTURE_FIRST  = 2;

   localparam logic [15:0] WANTED_RESET = 16'h0001;

   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_ATTR_HDR = 2'd1,
      PH_ATTR_VAL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_RUNT_PACKET  = 2'd1,
      ST_RUNT_ATTR    = 2'd2,
      ST_ATTR_OVERRUN = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] msg_type;
      logic        length_short;
      logic        found;
      logic [15:0] port;
      logic [31:0] address;
   } result_type;

endpackage

// ----- rtl/core/sap_parser.sv -----
module sap_parser #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          byte_value,
   input  logic                last_byte,
   input  logic [15:0]         wanted_attr_type,
   output sap_pkg::result_type result
);

   localparam int unsigned PosWidth = $clog2(MAX_PAYLOAD + 1);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0]         hdr_type_ff, hdr_type_in;
   logic [15:0]         adv_len_ff, adv_len_in;
   sap_pkg::phase_type  phase_ff, phase_in;
   logic [15:0]         cnt_ff, cnt_in;
   logic [15:0]         attr_type_ff, attr_type_in;
   logic [15:0]         attr_len_ff, attr_len_in;
   logic [47:0]         capture_ff, capture_in;
   logic                stopped_ff, stopped_in;
   logic                found_ff, found_in;
   logic [47:0]         port_addr_ff, port_addr_in;

   logic                finish;
   logic [16:0]         body_pos;
   logic [16:0]         body_len;
   logic [15:0]         cnt_inc;

   always_comb begin
      pos_in       = pos_ff;
      hdr_type_in  = hdr_type_ff;
      adv_len_in   = adv_len_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      attr_type_in = attr_type_ff;
      attr_len_in  = attr_len_ff;
      capture_in   = capture_ff;
      stopped_in   = stopped_ff;
      found_in     = found_ff;
      port_addr_in = port_addr_ff;
      finish       = 1'b0;
      cnt_inc      = cnt_ff + 16'd1;
      body_pos     = 17'(pos_ff) - 17'(sap_pkg::HDR_BYTES);
      result       = '0;

      if (step) begin
         if (pos_ff < PosWidth'(MAX_PAYLOAD)) begin
            pos_in = pos_ff + PosWidth'(1);
            if (pos_ff < PosWidth'(sap_pkg::HDR_BYTES)) begin
               case (pos_ff)
                  PosWidth'(0): hdr_type_in = {byte_value, 8'h00};
                  PosWidth'(1): hdr_type_in = {hdr_type_ff[15:8], byte_value};
                  PosWidth'(2): adv_len_in  = {byte_value, 8'h00};
                  PosWidth'(3): adv_len_in  = {adv_len_ff[15:8], byte_value};
                  default: ;
               endcase
               if (pos_ff == PosWidth'(sap_pkg::HDR_BYTES - 1)) begin
                  phase_in = sap_pkg::PH_ATTR_HDR;
                  cnt_in   = '0;
               end
            end else if (body_pos < {1'b0, adv_len_ff} && !stopped_ff) begin
               if (phase_ff == sap_pkg::PH_ATTR_VAL) begin
                  if (cnt_ff >= 16'(sap_pkg::CAPTURE_FIRST) &&
                      cnt_ff < 16'(sap_pkg::ADDR_VALUE_LEN)) begin
                     capture_in = {capture_ff[39:0], byte_value};
                  end
                  cnt_in = cnt_inc;
                  if (cnt_inc >= attr_len_ff) begin
                     finish = 1'b1;
                  end
               end else begin
                  case (cnt_ff[1:0])
                     2'd0:    attr_type_in = {byte_value, 8'h00};
                     2'd1:    attr_type_in = {attr_type_ff[15:8], byte_value};
                     2'd2:    attr_len_in  = {byte_value, 8'h00};
                     default: attr_len_in  = {attr_len_ff[15:8], byte_value};
                  endcase
                  cnt_in = cnt_inc;
                  if (cnt_inc >= 16'(sap_pkg::ATTR_HDR_BYTES)) begin
                     capture_in = '0;
                     cnt_in     = '0;
                     if (attr_len_in == 16'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = sap_pkg::PH_ATTR_VAL;
                     end
                  end
               end
            end else begin
               stopped_in = 1'b1;
            end
         end

         if (finish) begin
            if (attr_type_in == wanted_attr_type &&
                attr_len_in == 16'(sap_pkg::ADDR_VALUE_LEN)) begin
               found_in     = 1'b1;
               port_addr_in = capture_in;
            end
            phase_in = sap_pkg::PH_ATTR_HDR;
            cnt_in   = '0;
         end
      end

      body_len = 17'(pos_in) - 17'(sap_pkg::HDR_BYTES);
      if (pos_in < PosWidth'(sap_pkg::HDR_BYTES)) begin
         result.status = sap_pkg::ST_RUNT_PACKET;
      end else begin
         result.msg_type     = hdr_type_in;
         result.length_short = {1'b0, adv_len_in} > body_len;
         if (phase_in == sap_pkg::PH_ATTR_VAL) begin
            result.status = sap_pkg::ST_ATTR_OVERRUN;
         end else if (phase_in == sap_pkg::PH_ATTR_HDR && cnt_in != 16'd0) begin
            result.status = sap_pkg::ST_RUNT_ATTR;
         end else begin
            result.status = sap_pkg::ST_OK;
         end
         if (found_in) begin
            result.found   = 1'b1;
            result.port    = port_addr_in[47:32];
            result.address = port_addr_in[31:0];
         end
      end

      if (step && last_byte) begin
         pos_in       = '0;
         hdr_type_in  = '0;
         adv_len_in   = '0;
         phase_in     = sap_pkg::PH_HEADER;
         cnt_in       = '0;
         attr_type_in = '0;
         attr_len_in  = '0;
         capture_in   = '0;
         stopped_in   = 1'b0;
         found_in     = 1'b0;
         port_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_type_ff  <= '0;
         adv_len_ff   <= '0;
         phase_ff     <= sap_pkg::PH_HEADER;
         cnt_ff       <= '0;
         attr_type_ff <= '0;
         attr_len_ff  <= '0;
         capture_ff   <= '0;
         stopped_ff   <= 1'b0;
         found_ff     <= 1'b0;
         port_addr_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         hdr_type_ff  <= hdr_type_in;
         adv_len_ff   <= adv_len_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         attr_type_ff <= attr_type_in;
         attr_len_ff  <= attr_len_in;
         capture_ff   <= capture_in;
         stopped_ff   <= stopped_in;
         found_ff     <= found_in;
         port_addr_ff <= port_addr_in;
      end
   end

endmodule

// ----- rtl/core/stun_address_attribute_parser_core.sv -----
// STUN reply parser: pulls the mapped (or changed) IPv4 address out of a reply.
// req_*: one payload byte per transfer in wire order, req_tlast on the final
// byte. Each transfer is registered in the input register, then parsed from there.
// rsp_*: one result per packet, produced by the byte carrying req_tlast. The
// result is registered from the parser when that byte leaves the input register,
// and is then shown on rsp_tvalid.
// Throughput is one byte per cycle unless a final byte waits on a result; the
// parse state is updated once per byte, so the parser never holds the input register.
// csr_*: write of the wanted attribute type (reset value 1); always ready. The
// user must write it only between packets; the block does not enforce this.
// Reset (synchronous) drops any byte in flight and any waiting result and
// returns the parser to the start of a packet; the wanted type returns to 1.
// Stall: a waiting result blocks only the next final byte. Ordinary bytes keep
// flowing; a final byte waits in the input register with req_tready low until
// rsp_tready takes the earlier result.
// Bytes beyond MAX_PAYLOAD in a packet are dropped, but their req_tlast still
// ends the packet.
module stun_address_attribute_parser_core #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status, msg_type, length_short, found, port, address
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // wanted_attr_type
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sap_pkg::result_type rsp_data_ff;
   logic [15:0]         wanted_ff;
   logic                advance;
   sap_pkg::result_type result;

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   sap_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .byte_value      (in_byte_ff),
      .last_byte       (in_last_ff),
      .wanted_attr_type(wanted_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wanted_ff    <= sap_pkg::WANTED_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            wanted_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.address, rsp_data_ff.port, rsp_data_ff.found,
                        rsp_data_ff.length_short, rsp_data_ff.msg_type,
                        rsp_data_ff.status};

   a_final_byte_reports: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_tvalid)
      else $error("final byte did not produce a result");

   a_stalled_final_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready |-> !req_tready && !advance)
      else $error("final byte parsed over a waiting result");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data_ff.found |->
         rsp_data_ff.port == 16'd0 && rsp_data_ff.address == 32'd0)
      else $error("address reported without a match");

   a_runt_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.status == sap_pkg::ST_RUNT_PACKET |->
         rsp_data_ff.msg_type == 16'd0 && !rsp_data_ff.found &&
         !rsp_data_ff.length_short)
      else $error("runt packet reported header fields");

endmodule
